FILE: hw/rtl/bprs_pkg.sv
// Shared types and constants for the bidirectional PWM ramp sequencer.
`timescale 1ns / 1ps

package bprs_pkg;

    localparam int unsigned CntW  = 8;
    localparam int unsigned DutyW = 16;
    localparam int unsigned DataW = 32;
    localparam int unsigned AddrW = 5;

    localparam logic [CntW-1:0]  TicksPerStepRst    = 8'd5;
    localparam logic [CntW-1:0]  StepsPerSecondRst  = 8'd20;
    localparam logic [CntW-1:0]  SecondsPerPhaseRst = 8'd5;
    localparam logic [DutyW-1:0] DutyStepRst        = 16'd100;
    localparam logic [DutyW-1:0] DutyMaxRst         = 16'd10000;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_TICKS_PER_STEP    = 3'd0,
        REG_STEPS_PER_SECOND  = 3'd1,
        REG_SECONDS_PER_PHASE = 3'd2,
        REG_DUTY_STEP         = 3'd3,
        REG_DUTY_MAX          = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_FWD_UP   = 3'd0,
        PH_FWD_DOWN = 3'd1,
        PH_REV_UP   = 3'd2,
        PH_REV_DOWN = 3'd3,
        PH_DONE     = 3'd4
    } phase_t;

    typedef struct packed {
        logic [CntW-1:0]  ticks_per_step;
        logic [CntW-1:0]  steps_per_second;
        logic [CntW-1:0]  seconds_per_phase;
        logic [DutyW-1:0] duty_step;
        logic [DutyW-1:0] duty_max;
    } cfg_t;

    typedef struct packed {
        logic [DutyW-1:0] duty_forward;
        logic [DutyW-1:0] duty_reverse;
        logic             drive_forward;
        logic             drive_reverse;
        logic [2:0]       phase;
        logic             finished;
    } result_t;

endpackage

FILE: hw/rtl/bprs_regs.sv
// APB configuration register file for the ramp sequencer.
`timescale 1ns / 1ps

module bprs_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bprs_pkg::AddrW-1:0] paddr,
    input  logic [bprs_pkg::DataW-1:0] pwdata,
    output logic [bprs_pkg::DataW-1:0] prdata,
    output logic                       pready,
    output bprs_pkg::cfg_t             cfg
);

    import bprs_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_step    <= TicksPerStepRst;
            cfg_reg.steps_per_second  <= StepsPerSecondRst;
            cfg_reg.seconds_per_phase <= SecondsPerPhaseRst;
            cfg_reg.duty_step         <= DutyStepRst;
            cfg_reg.duty_max          <= DutyMaxRst;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TICKS_PER_STEP:    cfg_reg.ticks_per_step    <= pwdata[CntW-1:0];
                REG_STEPS_PER_SECOND:  cfg_reg.steps_per_second  <= pwdata[CntW-1:0];
                REG_SECONDS_PER_PHASE: cfg_reg.seconds_per_phase <= pwdata[CntW-1:0];
                REG_DUTY_STEP:         cfg_reg.duty_step         <= pwdata[DutyW-1:0];
                REG_DUTY_MAX:          cfg_reg.duty_max          <= pwdata[DutyW-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TICKS_PER_STEP:
                prdata = {{(DataW-CntW){1'b0}}, cfg_reg.ticks_per_step};
            REG_STEPS_PER_SECOND:
                prdata = {{(DataW-CntW){1'b0}}, cfg_reg.steps_per_second};
            REG_SECONDS_PER_PHASE:
                prdata = {{(DataW-CntW){1'b0}}, cfg_reg.seconds_per_phase};
            REG_DUTY_STEP:
                prdata = {{(DataW-DutyW){1'b0}}, cfg_reg.duty_step};
            REG_DUTY_MAX:
                prdata = {{(DataW-DutyW){1'b0}}, cfg_reg.duty_max};
            default:
                prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/bidirectional_pwm_ramp_sequencer.sv
// Top level: H-bridge soft-start ramp sequencer with two-entry result buffer.
// An accepted tick's result is registered in the output entry, or the skid entry on stall.
// Throughput: one tick per cycle while in_stall is low.
// The state update is one counter chain and one duty add; a two-entry output buffer
// takes one more input transfer after the output stalls. Reset (rst_n, async, active low)
// clears counters, duties, enables and phase and restores the register defaults.
`timescale 1ns / 1ps

module bidirectional_pwm_ramp_sequencer
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bprs_pkg::AddrW-1:0]   paddr,
    input  logic [bprs_pkg::DataW-1:0]   pwdata,
    output logic [bprs_pkg::DataW-1:0]   prdata,
    output logic                         pready,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         tick,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bprs_pkg::DutyW-1:0]   duty_forward,
    output logic [bprs_pkg::DutyW-1:0]   duty_reverse,
    output logic                         drive_forward,
    output logic                         drive_reverse,
    output logic [2:0]                   phase,
    output logic                         finished
);

    import bprs_pkg::*;

    cfg_t cfg;

    bprs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer state
    logic [CntW-1:0]  tick_cnt_reg,   tick_cnt_next;
    logic [CntW-1:0]  step_cnt_reg,   step_cnt_next;
    logic [CntW-1:0]  sec_cnt_reg,    sec_cnt_next;
    phase_t           phase_reg,      phase_next;
    logic             started_reg,    started_next;
    logic [DutyW-1:0] fwd_duty_reg,   fwd_duty_next;
    logic [DutyW-1:0] rev_duty_reg,   rev_duty_next;
    logic             fwd_en_reg,     fwd_en_next;
    logic             rev_en_reg,     rev_en_next;

    // result buffer
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg,  out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    logic             in_accept;
    logic             out_take;
    logic [CntW-1:0]  tick_inc, step_inc, sec_inc;
    logic             do_step;
    logic             forward_side;
    logic [DutyW-1:0] ramp_src;
    logic [DutyW:0]   up_sum;
    logic [DutyW-1:0] up_val;
    logic [DutyW-1:0] down_val;
    result_t          res;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    assign forward_side = (phase_reg == PH_FWD_UP) || (phase_reg == PH_FWD_DOWN);
    assign ramp_src     = forward_side ? fwd_duty_reg : rev_duty_reg;
    assign up_sum       = {1'b0, ramp_src} + {1'b0, cfg.duty_step};
    assign up_val       = (up_sum > {1'b0, cfg.duty_max}) ? cfg.duty_max : up_sum[DutyW-1:0];
    assign down_val     = (ramp_src > cfg.duty_step) ? (ramp_src - cfg.duty_step) : '0;

    assign tick_inc = tick_cnt_reg + 1'b1;
    assign step_inc = step_cnt_reg + 1'b1;
    assign sec_inc  = sec_cnt_reg + 1'b1;
    // a limit of zero behaves as one: the compare always passes
    assign do_step  = tick && (phase_reg != PH_DONE) && (tick_inc >= cfg.ticks_per_step);

    always_comb
    begin
        tick_cnt_next = tick_cnt_reg;
        step_cnt_next = step_cnt_reg;
        sec_cnt_next  = sec_cnt_reg;
        phase_next    = phase_reg;
        started_next  = started_reg;
        fwd_duty_next = fwd_duty_reg;
        rev_duty_next = rev_duty_reg;
        fwd_en_next   = fwd_en_reg;
        rev_en_next   = rev_en_reg;

        if (tick && (phase_reg != PH_DONE))
        begin
            tick_cnt_next = tick_inc;
            if (do_step)
            begin
                tick_cnt_next = '0;
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    fwd_en_next  = forward_side;
                    rev_en_next  = !forward_side;
                end
                case (phase_reg)
                    PH_FWD_UP:   fwd_duty_next = up_val;
                    PH_FWD_DOWN: fwd_duty_next = down_val;
                    PH_REV_UP:   rev_duty_next = up_val;
                    default:     rev_duty_next = down_val;
                endcase
                step_cnt_next = step_inc;
                if (step_inc >= cfg.steps_per_second)
                begin
                    step_cnt_next = '0;
                    sec_cnt_next  = sec_inc;
                    if (sec_inc >= cfg.seconds_per_phase)
                    begin
                        sec_cnt_next = '0;
                        phase_next   = phase_t'(phase_reg + 3'd1);
                        started_next = 1'b0;
                        if (phase_reg == PH_REV_DOWN)
                        begin
                            fwd_en_next = 1'b0;
                            rev_en_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        res.duty_forward  = fwd_duty_next;
        res.duty_reverse  = rev_duty_next;
        res.drive_forward = fwd_en_next;
        res.drive_reverse = rev_en_next;
        res.phase         = phase_next;
        res.finished      = (phase_next == PH_DONE);
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_accept)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_cnt_reg   <= '0;
            step_cnt_reg   <= '0;
            sec_cnt_reg    <= '0;
            phase_reg      <= PH_FWD_UP;
            started_reg    <= 1'b0;
            fwd_duty_reg   <= '0;
            rev_duty_reg   <= '0;
            fwd_en_reg     <= 1'b0;
            rev_en_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                tick_cnt_reg <= tick_cnt_next;
                step_cnt_reg <= step_cnt_next;
                sec_cnt_reg  <= sec_cnt_next;
                phase_reg    <= phase_next;
                started_reg  <= started_next;
                fwd_duty_reg <= fwd_duty_next;
                rev_duty_reg <= rev_duty_next;
                fwd_en_reg   <= fwd_en_next;
                rev_en_reg   <= rev_en_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign duty_forward  = out_data_reg.duty_forward;
    assign duty_reverse  = out_data_reg.duty_reverse;
    assign drive_forward = out_data_reg.drive_forward;
    assign drive_reverse = out_data_reg.drive_reverse;
    assign phase         = out_data_reg.phase;
    assign finished      = out_data_reg.finished;

    // the bridge must never have both sides driven
    a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
        !(fwd_en_reg && rev_en_reg))
        else $error("both drives enabled");

    a_done_drives_off: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> (!fwd_en_reg && !rev_en_reg && started_reg == 1'b0))
        else $error("drive left on after sequence end");

    a_phase_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (phase_reg >= $past(phase_reg)))
        else $error("phase went backwards");

    a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> ($past(out_valid_reg) && $past(out_stall)))
        else $error("skid entry filled without output stall");

endmodule
